/* src/sst_pkg.sv */
// Shared types and codes for the sorted set table.
// Used by the cell, the control and the top level; depends on nothing.
package sst_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int FIELD_W   = 5;    // width of position, entry_count and limit fields
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [FIELD_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Shift command broadcast from the control to every cell.
    typedef struct packed {
        logic ins;   // open a slot at the first entry not below the key
        logic rem;   // close the slot of the matching entry
    } cell_op_t;

endpackage

/* src/sst_cell.sv */
// One slot of the sorted store: holds an entry, compares it with the key,
// and takes a neighbor's entry on a shift. Depends on sst_pkg.
module sst_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                        aclk,
    input  logic                        cap_en,     // latch compare flags
    input  logic [sst_pkg::KEY_W-1:0]   cmp_key,    // key of the incoming request
    input  logic [CNT_W-1:0]            count,      // entries held now
    input  sst_pkg::cell_op_t           op,
    input  logic [sst_pkg::KEY_W-1:0]   upd_key,    // key of the request in work
    input  logic                        prev_lt,    // left neighbor is below the key
    input  logic [sst_pkg::KEY_W-1:0]   prev_entry,
    input  logic [sst_pkg::KEY_W-1:0]   next_entry,
    output logic [sst_pkg::KEY_W-1:0]   entry,
    output logic                        lt,
    output logic                        eq
);
    import sst_pkg::*;

    logic [KEY_W-1:0] entry_reg, entry_next;
    logic             lt_reg, eq_reg;
    logic             valid;

    assign valid = (count > CNT_W'(INDEX));

    always_comb begin
        entry_next = entry_reg;
        if (op.ins && !lt_reg) begin
            entry_next = prev_lt ? upd_key : prev_entry;
        end else if (op.rem && !lt_reg) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (cap_en) begin
            lt_reg <= valid && ($signed(entry_reg) < $signed(cmp_key));
            eq_reg <= valid && (entry_reg == cmp_key);
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

/* src/sst_ctrl.sv */
// Decision logic: turns the cell flags into the shift command and the result.
// Depends on sst_pkg.
module sst_ctrl #(
    parameter int DEPTH = sst_pkg::DEPTH_DEF,
    parameter int CNT_W = 5
) (
    input  logic [DEPTH-1:0]                lt_vec,
    input  logic [DEPTH-1:0]                eq_vec,
    input  logic [sst_pkg::CMD_W-1:0]       cmd,
    input  logic [CNT_W-1:0]                count,
    input  logic [sst_pkg::FIELD_W-1:0]     cap,
    output sst_pkg::cell_op_t               op,
    output logic [CNT_W-1:0]                count_next,
    output logic [sst_pkg::STATUS_W-1:0]    status,
    output logic [sst_pkg::FIELD_W-1:0]     position,
    output logic                            found
);
    import sst_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDE  = CNT_W + FIELD_W;

    logic [IDX_W-1:0] hit_idx;
    logic [WIDE-1:0]  cnt_wide, cap_wide, pos_wide;
    logic             full;
    logic             use_idx;

    // Values are distinct, so at most one eq flag is set: OR-encode it.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (eq_vec[i]) hit_idx = hit_idx | IDX_W'(i);
        end
    end

    assign found    = |eq_vec;
    assign cnt_wide = WIDE'(count);
    assign cap_wide = WIDE'(cap);
    assign full     = (cnt_wide >= cap_wide) || (count == CNT_W'(DEPTH));

    always_comb begin
        op         = '0;
        count_next = count;
        use_idx    = found;
        status     = found ? ST_DONE : ST_MISSING;
        case (cmd)
            CMD_INSERT: begin
                if (found) begin
                    status = ST_PRESENT;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    status     = ST_DONE;
                    op.ins     = 1'b1;
                    use_idx    = 1'b1;
                    count_next = count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (found) begin
                    op.rem     = 1'b1;
                    count_next = count - CNT_W'(1);
                end
            end
            default: begin
                // query and the unused code: look up only
            end
        endcase
    end

    // Insert of a new value lands at the number of entries below the key.
    logic [CNT_W-1:0] below_cnt;
    always_comb begin
        below_cnt = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lt_vec[i] && (i == DEPTH - 1 || !lt_vec[(i + 1) % DEPTH])) begin
                below_cnt = below_cnt | CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        if (!use_idx) begin
            pos_wide = cnt_wide;
        end else if (found) begin
            pos_wide = WIDE'(hit_idx);
        end else begin
            pos_wide = WIDE'(below_cnt);
        end
    end

    assign position = pos_wide[FIELD_W-1:0];

endmodule

/* src/sorted_set_table_unit.sv */
// Sorted set table: distinct signed 32-bit keys kept in ascending order.
// A request is accepted and its compare flags are latched in the cells; then the
// cell chain shifts and the result is loaded. No new request is taken while one
// is in work or while an earlier result still waits in the result slot.
// Reset (aresetn low, synchronous): count cleared, limit back to 16, result
// channel emptied; stored entries stay undefined until written.
module sorted_set_table_unit #(
    parameter int DEPTH = sst_pkg::DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // cmd[1:0], key_value[33:2], zero pad
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // status[1:0], position[6:2],
                                                   // found[7], entry_count[12:8], pad
    // limit register
    input  logic                        cfg_wr_en,
    input  logic [sst_pkg::FIELD_W-1:0] cfg_wr_data
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WIDE  = CNT_W + FIELD_W;

    // control state
    logic                busy_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [FIELD_W-1:0]  cap_reg;
    logic                m_tvalid_reg;
    // request in work and result payload
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [15:0]         m_tdata_reg;

    logic                accept;
    logic [CMD_W-1:0]    in_cmd;
    logic [KEY_W-1:0]    in_key;

    logic [DEPTH-1:0]    lt_vec, eq_vec;
    logic [KEY_W-1:0]    entries [DEPTH];
    cell_op_t            op, op_live;

    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  position;
    logic                found;
    logic [WIDE-1:0]     cnt_wide;

    assign in_cmd = s_tdata[CMD_W-1:0];
    assign in_key = s_tdata[CMD_W+KEY_W-1:CMD_W];

    // Take a request only when idle and the result slot frees by the next edge.
    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Shift the chain only in the cycle the request is resolved.
    assign op_live.ins = op.ins && busy_reg;
    assign op_live.rem = op.rem && busy_reg;

    // Row of cells: each compares the broadcast key and takes a neighbor's entry on a shift.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic             prev_lt_w;
        logic [KEY_W-1:0] prev_entry_w, next_entry_w;

        if (i == 0) begin : g_first
            assign prev_lt_w    = 1'b1;
            assign prev_entry_w = key_reg;
        end else begin : g_mid
            assign prev_lt_w    = lt_vec[i-1];
            assign prev_entry_w = entries[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_entry_w = entries[i];
        end else begin : g_inner
            assign next_entry_w = entries[i+1];
        end

        sst_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cap_en     (accept),
            .cmp_key    (in_key),
            .count      (count_reg),
            .op         (op_live),
            .upd_key    (key_reg),
            .prev_lt    (prev_lt_w),
            .prev_entry (prev_entry_w),
            .next_entry (next_entry_w),
            .entry      (entries[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    sst_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .lt_vec     (lt_vec),
        .eq_vec     (eq_vec),
        .cmd        (cmd_reg),
        .count      (count_reg),
        .cap        (cap_reg),
        .op         (op),
        .count_next (count_next),
        .status     (status),
        .position   (position),
        .found      (found)
    );

    assign cnt_wide = WIDE'(count_next);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            busy_reg <= accept;
            if (busy_reg) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // request and result payload: hold the request, load the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
        end
        if (busy_reg) begin
            m_tdata_reg <= {3'b000, cnt_wide[FIELD_W-1:0], found, position, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/sst_checker.sv */
// Port-level checks for the sorted set table unit, bound to the top level.
// Depends on sst_pkg for the status codes.
module sst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import sst_pkg::*;

    logic [STATUS_W-1:0] st;
    logic [FIELD_W-1:0]  pos, cnt;

    assign st  = m_tdata[1:0];
    assign pos = m_tdata[6:2];
    assign cnt = m_tdata[12:8];

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request at a time: no accept right after an accept.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // Every accepted request is followed by a valid result.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing after request");

    // Full and not-found results report the entry count as position.
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL || st == ST_MISSING) |-> pos == cnt && !m_tdata[7])
        else $error("absent key position mismatch");

    // Already-present implies found.
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == ST_PRESENT |-> m_tdata[7])
        else $error("present status without found flag");

endmodule

bind sorted_set_table_unit sst_checker u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
